@@ hw/rtl/fpcd_pkg.sv @@
// Package with the code table, command codes and controller/datapath interface types.
`default_nettype none

package fpcd_pkg;

    // Command carried in tuser of an input request.
    localparam logic CMD_DECODE = 1'b0;
    localparam logic CMD_FLUSH  = 1'b1;

    // Longest code in the table; an unmatched run of this length is dropped.
    localparam logic [2:0] MAX_CODE_LEN = 3'd7;

    // Value returned by the table lookup when no code matches.
    localparam logic [6:0] NO_LETTER = 7'd0;

    // Controller to datapath commands.
    typedef struct packed {
        logic load;      // take a new data byte
        logic flush;     // drop the unfinished code bits
        logic step;      // consume one code bit
        logic push_end;  // hand the held letter to the output as the last one
    } t_dp_cmd;

    // Datapath to controller status.
    typedef struct packed {
        logic found;       // the next code bit completes a letter
        logic held_valid;  // a decoded letter waits in the hold register
        logic out_free;    // the output register can take a letter this cycle
        logic last_bit;    // the current bit is bit 0 of the byte
    } t_dp_status;

    // Returns the ASCII letter for an exact code match, or NO_LETTER.
    function automatic logic [6:0] match_code(input logic [6:0] bits, input logic [2:0] len);
        logic [6:0] letter;
        letter = NO_LETTER;
        unique case ({len, bits})
            {3'd3, 7'd0}:   letter = 7'd101; // e
            {3'd4, 7'd2}:   letter = 7'd116; // t
            {3'd4, 7'd3}:   letter = 7'd97;  // a
            {3'd4, 7'd4}:   letter = 7'd111; // o
            {3'd4, 7'd5}:   letter = 7'd110; // n
            {3'd4, 7'd6}:   letter = 7'd114; // r
            {3'd4, 7'd7}:   letter = 7'd105; // i
            {3'd5, 7'd16}:  letter = 7'd104; // h
            {3'd5, 7'd17}:  letter = 7'd115; // s
            {3'd5, 7'd18}:  letter = 7'd100; // d
            {3'd5, 7'd19}:  letter = 7'd108; // l
            {3'd5, 7'd20}:  letter = 7'd99;  // c
            {3'd5, 7'd21}:  letter = 7'd117; // u
            {3'd5, 7'd22}:  letter = 7'd109; // m
            {3'd5, 7'd23}:  letter = 7'd102; // f
            {3'd5, 7'd24}:  letter = 7'd112; // p
            {3'd5, 7'd25}:  letter = 7'd121; // y
            {3'd5, 7'd26}:  letter = 7'd98;  // b
            {3'd5, 7'd27}:  letter = 7'd119; // w
            {3'd5, 7'd28}:  letter = 7'd103; // g
            {3'd5, 7'd29}:  letter = 7'd118; // v
            {3'd6, 7'd60}:  letter = 7'd106; // j
            {3'd6, 7'd61}:  letter = 7'd107; // k
            {3'd6, 7'd62}:  letter = 7'd120; // x
            {3'd7, 7'd126}: letter = 7'd113; // q
            {3'd7, 7'd127}: letter = 7'd122; // z
            default:        letter = NO_LETTER;
        endcase
        return letter;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/fpcd_dp.sv @@
// Datapath: byte shifter, code accumulator, letter hold register and output register.
`default_nettype none

module fpcd_dp (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  fpcd_pkg::t_dp_cmd    i_cmd,
    output fpcd_pkg::t_dp_status o_status,
    input  wire [7:0]            i_byte,
    output logic                 o_m_tvalid,
    input  wire                  i_m_tready,
    output logic [7:0]           o_m_tdata,   // [6:0] letter, [7] zero
    output logic                 o_m_tlast    // last letter of the byte
);
    import fpcd_pkg::*;

    logic [7:0] r_byte;
    logic [2:0] r_bitcnt;
    logic [5:0] r_acc;
    logic [2:0] r_cnt;
    logic [6:0] r_held;
    logic       r_held_valid;
    logic [6:0] r_out_letter;
    logic       r_out_last;
    logic       r_out_valid;

    logic [6:0] n_acc;
    logic [2:0] n_cnt;
    logic [6:0] w_letter;
    logic       w_found;
    logic       w_out_free;
    logic       w_push;

    // Extend the unfinished code by the current bit and look it up.
    always_comb begin
        n_acc    = {r_acc, r_byte[7]};
        n_cnt    = r_cnt + 3'd1;
        w_letter = match_code(n_acc, n_cnt);
        w_found  = (w_letter != NO_LETTER);
    end

    assign w_out_free = !r_out_valid || i_m_tready;
    assign w_push     = (i_cmd.step && w_found && r_held_valid) || i_cmd.push_end;

    assign o_status.found      = w_found;
    assign o_status.held_valid = r_held_valid;
    assign o_status.out_free   = w_out_free;
    assign o_status.last_bit   = (r_bitcnt == 3'd7);

    // Byte shifter and bit counter.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_byte   <= i_byte;
            r_bitcnt <= 3'd0;
        end else if (i_cmd.step) begin
            r_byte   <= {r_byte[6:0], 1'b0};
            r_bitcnt <= r_bitcnt + 3'd1;
        end
    end

    // Unfinished code bits; cleared after a letter or a run of the longest length.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.flush) begin
            r_acc <= '0;
            r_cnt <= '0;
        end else if (i_cmd.step) begin
            if (w_found || n_cnt >= MAX_CODE_LEN) begin
                r_acc <= '0;
                r_cnt <= '0;
            end else begin
                r_acc <= n_acc[5:0];
                r_cnt <= n_cnt;
            end
        end
    end

    // The newest letter waits here until it is known whether it ends the byte.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_valid <= 1'b0;
        end else if (i_cmd.step && w_found) begin
            r_held_valid <= 1'b1;
        end else if (i_cmd.push_end) begin
            r_held_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.step && w_found) begin
            r_held <= w_letter;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_push) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_out_letter <= r_held;
            r_out_last   <= i_cmd.push_end;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {1'b0, r_out_letter};
    assign o_m_tlast  = r_out_last;

    // At most six code bits ever stay pending.
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 3'd6)
        else $error("pending bit count out of range");

    // A completed letter restarts decoding at the root.
    a_root_after_letter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.step && w_found |=> r_cnt == 3'd0 && r_acc == 6'd0)
        else $error("decoder not back at root after a letter");

    // A flush drops every unfinished bit.
    a_flush_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.flush |=> r_cnt == 3'd0 && r_acc == 6'd0)
        else $error("flush left pending bits");

    // A letter is only moved to the output when the output register has room.
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> w_out_free)
        else $error("letter pushed over a waiting result");

endmodule

`default_nettype wire

@@ hw/rtl/fpcd_ctrl.sv @@
// Controller: state machine that sequences the eight bits of each byte.
`default_nettype none

module fpcd_ctrl (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_s_tvalid,
    output logic                 o_s_tready,
    input  wire                  i_command,
    input  fpcd_pkg::t_dp_status i_status,
    output fpcd_pkg::t_dp_cmd    o_cmd
);
    import fpcd_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_BIT  = 2'd1;
    localparam logic [1:0] S_END  = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    // Next state and datapath commands.
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_s_tready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    if (i_command == CMD_FLUSH) begin
                        o_cmd.flush = 1'b1;
                    end else begin
                        o_cmd.load = 1'b1;
                        n_state    = S_BIT;
                    end
                end
            end
            S_BIT: begin
                // Hold the bit while an earlier letter cannot leave the hold register.
                if (!(i_status.found && i_status.held_valid && !i_status.out_free)) begin
                    o_cmd.step = 1'b1;
                    if (i_status.last_bit) begin
                        n_state = S_END;
                    end
                end
            end
            S_END: begin
                if (!i_status.held_valid) begin
                    n_state = S_IDLE;
                end else if (i_status.out_free) begin
                    o_cmd.push_end = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Requests are taken only in the idle state.
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_s_tready |-> r_state == S_IDLE)
        else $error("request taken while busy");

    // A data byte always leads to bit processing.
    a_load_to_bit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> r_state == S_BIT)
        else $error("loaded byte not processed");

    // The idle state never holds a decoded letter.
    a_idle_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_IDLE |-> !i_status.held_valid)
        else $error("letter left behind in idle");

endmodule

`default_nettype wire

@@ hw/rtl/fixed_prefix_code_letter_decoder.sv @@
// Top level of the fixed prefix-code letter decoder.
//
// Input requests arrive on the slave stream: tdata carries a coded byte, read from
// bit 7 down to bit 0, and tuser selects decode (0) or flush (1). A flush drops the
// unfinished code bits and gives no result. Each decoded lower-case
// letter leaves on the master stream as ASCII in tdata[6:0]; tlast marks the last
// letter that a byte produced. A byte gives zero to three letters.
// A data byte is accepted in the idle state. Its eight bits then walk through the
// code table one per cycle while the output is not stalled, and the end state hands
// on its last letter. A letter shows on the output in the cycle after the bit that
// completes the following letter, or when the end state hands on the byte's last
// letter, since a letter is held until it is known whether it ends the byte.
// When the receiver stalls, one letter waits in the output register and one in the
// hold register; bit processing then pauses, and the next request is taken once the
// byte is done. Unfinished code bits carry over from byte to byte.
// Reset (synchronous, active low) returns the decoder to the root of the code and
// empties the output.
`default_nettype none

module fixed_prefix_code_letter_decoder (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_s_tvalid,
    output logic       o_s_tready,
    input  wire [7:0]  i_s_tdata,   // [7:0] data_byte
    input  wire [0:0]  i_s_tuser,   // [0] command
    output logic       o_m_tvalid,
    input  wire        i_m_tready,
    output logic [7:0] o_m_tdata,   // [6:0] letter, [7] zero
    output logic       o_m_tlast    // last
);
    import fpcd_pkg::*;

    t_dp_cmd    w_cmd;
    t_dp_status w_status;

    fpcd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_command  (i_s_tuser[0]),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    fpcd_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_status   (w_status),
        .i_byte     (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

endmodule

`default_nettype wire
